// File: hw/rtl/mhw_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mhw_pkg
// Shared constants and register codes of the mesh homography warp map block.
// ----------------------------------------------------------------------------
package mhw_pkg;

  localparam int PIX_W        = 13;  // pixel coordinate width
  localparam int CELL_W       = 12;  // cell number field width
  localparam int SLOT_W       = 4;   // coefficient slot field width
  localparam int CANVAS_REG_W = 14;
  localparam int MESH_REG_W   = 7;
  localparam int SHIFT_W      = 22;  // unsigned Q14.8 offset
  localparam int FRAC_IN      = 8;   // fraction bits of the offset pixel
  localparam int OFS_W        = 23;  // signed offset pixel, Q.8
  localparam int FRAC_OUT     = 12;  // fraction bits of u,v
  localparam int QUO_BITS     = 32;  // result width
  localparam int NUM_SLOTS    = 9;   // 3x3 homography
  localparam int CFG_DATA_W   = 22;
  localparam int CFG_IDX_W    = 3;

  // request kinds on the input channel
  localparam logic REQ_WRITE = 1'b0;
  localparam logic REQ_MAP   = 1'b1;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_CANVAS_WIDTH  = 3'd0,
    REG_CANVAS_HEIGHT = 3'd1,
    REG_MESH_COLUMNS  = 3'd2,
    REG_MESH_ROWS     = 3'd3,
    REG_SHIFT_X       = 3'd4,
    REG_SHIFT_Y       = 3'd5
  } cfg_reg_t;

  localparam logic [QUO_BITS-1:0] SAT_POS = 32'h7FFF_FFFF;
  localparam logic [QUO_BITS-1:0] SAT_NEG = 32'h8000_0000;

endpackage

// File: hw/rtl/mesh_homography_warp_map_core.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mesh_homography_warp_map_core
// Per-pixel inverse map for a mesh warp: cell lookup, projective transform
// and divide by w, fully pipelined.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel (in_valid/in_ready) carries two kinds of transaction. A
//   coefficient write (in_req_type = 0) stores in_coef_value at slot
//   in_coef_slot of cell in_cell_number and returns nothing; out-of-range
//   cells or slots are dropped. A map request (in_req_type = 1) returns one
//   result transaction on out_valid/out_ready with u, v in Q19.12, the cell
//   used and the zero_depth / clipped flags.
//   A map request passes through the pipelined cell-index divider (one stage
//   per index bit) and the 32-stage quotient divider. Throughput is one
//   transaction per cycle while the output is not stalled; all stages advance
//   together.
//   The output register decouples the sides: when it is empty or being taken
//   the whole pipeline advances and in_ready is high. When the receiver
//   stalls with a result held, every stage holds, nothing is lost.
//   Reset clears all valid bits and loads the register defaults (1024x1024
//   canvas, 64x64 mesh, zero offset). The coefficient table is not cleared;
//   write every coefficient of a cell before mapping pixels into it.
//   Configuration writes take effect at once; issue them only while idle.
// ----------------------------------------------------------------------------
module mesh_homography_warp_map_core #(
  parameter int MESH_DIM_MAX   = 64,
  parameter int CANVAS_DIM_MAX = 8192,
  parameter int COEF_BITS      = 48
) (
  input  logic                                 clk,
  input  logic                                 rst_n,
  // configuration port
  input  logic                                 cfg_wr_en,
  input  logic [mhw_pkg::CFG_IDX_W-1:0]        cfg_index,
  input  logic [mhw_pkg::CFG_DATA_W-1:0]       cfg_wdata,
  // input channel
  input  logic                                 in_valid,
  output logic                                 in_ready,
  input  logic                                 in_req_type,
  input  logic [mhw_pkg::CELL_W-1:0]           in_cell_number,
  input  logic [mhw_pkg::SLOT_W-1:0]           in_coef_slot,
  input  logic signed [COEF_BITS-1:0]          in_coef_value,
  input  logic [mhw_pkg::PIX_W-1:0]            in_pixel_x,
  input  logic [mhw_pkg::PIX_W-1:0]            in_pixel_y,
  // result channel
  output logic                                 out_valid,
  input  logic                                 out_ready,
  output logic signed [mhw_pkg::QUO_BITS-1:0]  out_source_u,
  output logic signed [mhw_pkg::QUO_BITS-1:0]  out_source_v,
  output logic [mhw_pkg::CELL_W-1:0]           out_used_cell,
  output logic                                 out_zero_depth,
  output logic                                 out_clipped
);

  // --------------------------------------------------------------------------
  // Derived sizes
  // --------------------------------------------------------------------------
  localparam int MW        = $clog2(MESH_DIM_MAX + 1);     // clamped mesh size
  localparam int CW        = $clog2(CANVAS_DIM_MAX + 1);   // clamped canvas size
  localparam int TBL_DEPTH = MESH_DIM_MAX * MESH_DIM_MAX;
  localparam int AW        = (TBL_DEPTH > 1) ? $clog2(TBL_DEPTH) : 1;
  localparam int NXW       = mhw_pkg::PIX_W + MW;          // pixel * mesh size
  localparam int PW        = COEF_BITS + mhw_pkg::OFS_W + 2; // projected sum
  localparam int HL        = COEF_BITS / 2;                // low coef half
  localparam int HH        = COEF_BITS - HL;               // high coef half
  localparam int QB        = mhw_pkg::QUO_BITS;
  localparam int HI_SH     = QB - mhw_pkg::FRAC_OUT;       // bits of n<<12 in low

  // --------------------------------------------------------------------------
  // Configuration registers
  // --------------------------------------------------------------------------
  logic [mhw_pkg::CANVAS_REG_W-1:0] cfg_width_r, cfg_height_r;
  logic [mhw_pkg::MESH_REG_W-1:0]   cfg_cols_r, cfg_rows_r;
  logic [mhw_pkg::SHIFT_W-1:0]      cfg_shift_x_r, cfg_shift_y_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_width_r   <= 14'd1024;
      cfg_height_r  <= 14'd1024;
      cfg_cols_r    <= 7'd64;
      cfg_rows_r    <= 7'd64;
      cfg_shift_x_r <= '0;
      cfg_shift_y_r <= '0;
    end else if (cfg_wr_en) begin
      case (cfg_index)
        mhw_pkg::REG_CANVAS_WIDTH:  cfg_width_r   <= cfg_wdata[mhw_pkg::CANVAS_REG_W-1:0];
        mhw_pkg::REG_CANVAS_HEIGHT: cfg_height_r  <= cfg_wdata[mhw_pkg::CANVAS_REG_W-1:0];
        mhw_pkg::REG_MESH_COLUMNS:  cfg_cols_r    <= cfg_wdata[mhw_pkg::MESH_REG_W-1:0];
        mhw_pkg::REG_MESH_ROWS:     cfg_rows_r    <= cfg_wdata[mhw_pkg::MESH_REG_W-1:0];
        mhw_pkg::REG_SHIFT_X:       cfg_shift_x_r <= cfg_wdata;
        mhw_pkg::REG_SHIFT_Y:       cfg_shift_y_r <= cfg_wdata;
        default: ;
      endcase
    end
  end

  // Clamp: zero reads as one, oversize saturates to the maximum.
  logic [MW-1:0] cols_c, rows_c;
  logic [CW-1:0] wid_c, hgt_c;

  always_comb begin
    if (cfg_cols_r == '0)                    cols_c = MW'(1);
    else if (int'(cfg_cols_r) > MESH_DIM_MAX) cols_c = MW'(MESH_DIM_MAX);
    else                                      cols_c = MW'(cfg_cols_r);
    if (cfg_rows_r == '0)                    rows_c = MW'(1);
    else if (int'(cfg_rows_r) > MESH_DIM_MAX) rows_c = MW'(MESH_DIM_MAX);
    else                                      rows_c = MW'(cfg_rows_r);
    if (cfg_width_r == '0)                      wid_c = CW'(1);
    else if (int'(cfg_width_r) > CANVAS_DIM_MAX) wid_c = CW'(CANVAS_DIM_MAX);
    else                                         wid_c = CW'(cfg_width_r);
    if (cfg_height_r == '0)                      hgt_c = CW'(1);
    else if (int'(cfg_height_r) > CANVAS_DIM_MAX) hgt_c = CW'(CANVAS_DIM_MAX);
    else                                          hgt_c = CW'(cfg_height_r);
  end

  // --------------------------------------------------------------------------
  // Global advance: every stage moves when the output register can take data.
  // --------------------------------------------------------------------------
  logic adv;
  logic out_valid_r;

  assign adv      = !out_valid_r || out_ready;
  assign in_ready = adv;

  // --------------------------------------------------------------------------
  // Stage 0: capture, offset pixel, scale for cell index, range check
  // --------------------------------------------------------------------------
  logic                          s0_vld_r;
  logic                          s0_map_r;
  logic [mhw_pkg::CELL_W-1:0]    s0_wcell_r;
  logic [mhw_pkg::SLOT_W-1:0]    s0_wslot_r;
  logic [COEF_BITS-1:0]          s0_wcoef_r;
  logic signed [mhw_pkg::OFS_W-1:0] s0_ox_r, s0_oy_r;
  logic [NXW-1:0]                s0_nx_r, s0_ny_r;
  logic                          s0_ovx_r, s0_ovy_r;

  logic [NXW-1:0]                nx_nxt, ny_nxt;
  logic signed [mhw_pkg::OFS_W-1:0] ox_nxt, oy_nxt;

  always_comb begin
    nx_nxt = NXW'(in_pixel_x) * NXW'(cols_c);
    ny_nxt = NXW'(in_pixel_y) * NXW'(rows_c);
    ox_nxt = $signed(mhw_pkg::OFS_W'({in_pixel_x, {mhw_pkg::FRAC_IN{1'b0}}}))
           - $signed(mhw_pkg::OFS_W'(cfg_shift_x_r));
    oy_nxt = $signed(mhw_pkg::OFS_W'({in_pixel_y, {mhw_pkg::FRAC_IN{1'b0}}}))
           - $signed(mhw_pkg::OFS_W'(cfg_shift_y_r));
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s0_vld_r <= 1'b0;
    end else if (adv) begin
      s0_vld_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      s0_map_r   <= (in_req_type == mhw_pkg::REQ_MAP);
      s0_wcell_r <= in_cell_number;
      s0_wslot_r <= in_coef_slot;
      s0_wcoef_r <= in_coef_value;
      s0_ox_r    <= ox_nxt;
      s0_oy_r    <= oy_nxt;
      s0_nx_r    <= nx_nxt;
      s0_ny_r    <= ny_nxt;
      // quotient would not fit the divider: clamp later
      s0_ovx_r   <= (nx_nxt >> MW) >= NXW'(wid_c);
      s0_ovy_r   <= (ny_nxt >> MW) >= NXW'(hgt_c);
    end
  end

  // --------------------------------------------------------------------------
  // Cell index dividers: floor(x*cols/width), floor(y*rows/height)
  // --------------------------------------------------------------------------
  logic [MW-1:0] qx, qy;

  mhw_div_pipe #(.DW(CW), .QW(MW)) u_div_x (
    .clk   (clk),
    .en    (adv),
    .rem_i (s0_ovx_r ? '0 : CW'(s0_nx_r >> MW)),
    .num_i (s0_nx_r[MW-1:0]),
    .den_i (wid_c),
    .quo_o (qx)
  );

  mhw_div_pipe #(.DW(CW), .QW(MW)) u_div_y (
    .clk   (clk),
    .en    (adv),
    .rem_i (s0_ovy_r ? '0 : CW'(s0_ny_r >> MW)),
    .num_i (s0_ny_r[MW-1:0]),
    .den_i (hgt_c),
    .quo_o (qy)
  );

  typedef struct packed {
    logic                             map;
    logic [mhw_pkg::CELL_W-1:0]       wcell;
    logic [mhw_pkg::SLOT_W-1:0]       wslot;
    logic [COEF_BITS-1:0]             wcoef;
    logic signed [mhw_pkg::OFS_W-1:0] ox;
    logic signed [mhw_pkg::OFS_W-1:0] oy;
    logic                             ovx;
    logic                             ovy;
  } sba_t;

  sba_t sba_r     [MW];
  logic sba_vld_r [MW];

  // Carry the transaction alongside the index divider.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int k = 0; k < MW; k++) sba_vld_r[k] <= 1'b0;
    end else if (adv) begin
      sba_vld_r[0] <= s0_vld_r;
      for (int k = 1; k < MW; k++) sba_vld_r[k] <= sba_vld_r[k-1];
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      sba_r[0] <= '{map: s0_map_r, wcell: s0_wcell_r, wslot: s0_wslot_r,
                    wcoef: s0_wcoef_r, ox: s0_ox_r, oy: s0_oy_r,
                    ovx: s0_ovx_r, ovy: s0_ovy_r};
      for (int k = 1; k < MW; k++) sba_r[k] <= sba_r[k-1];
    end
  end

  // --------------------------------------------------------------------------
  // Stage 1: clamp index to grid, form row-major cell
  // --------------------------------------------------------------------------
  sba_t              sa;
  logic [MW-1:0]     ix, iy;
  logic [2*MW-1:0]   cell_nxt;

  assign sa = sba_r[MW-1];

  always_comb begin
    ix = (sa.ovx || qx >= cols_c) ? cols_c - MW'(1) : qx;
    iy = (sa.ovy || qy >= rows_c) ? rows_c - MW'(1) : qy;
    cell_nxt = (2*MW)'(iy) * (2*MW)'(cols_c) + (2*MW)'(ix);
  end

  logic                             s1_vld_r;
  logic                             s1_map_r;
  logic [2*MW-1:0]                  s1_cell_r;
  logic [mhw_pkg::CELL_W-1:0]       s1_wcell_r;
  logic [mhw_pkg::SLOT_W-1:0]       s1_wslot_r;
  logic [COEF_BITS-1:0]             s1_wcoef_r;
  logic signed [mhw_pkg::OFS_W-1:0] s1_ox_r, s1_oy_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_vld_r <= 1'b0;
    end else if (adv) begin
      s1_vld_r <= sba_vld_r[MW-1];
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      s1_map_r   <= sa.map;
      s1_cell_r  <= cell_nxt;
      s1_wcell_r <= sa.wcell;
      s1_wslot_r <= sa.wslot;
      s1_wcoef_r <= sa.wcoef;
      s1_ox_r    <= sa.ox;
      s1_oy_r    <= sa.oy;
    end
  end

  // --------------------------------------------------------------------------
  // Stage 2: coefficient table, one RAM per slot. Writes land here in order,
  // so a later map transaction always sees them.
  // --------------------------------------------------------------------------
  logic [AW-1:0]        tbl_addr;
  logic                 wr_ok;
  logic [COEF_BITS-1:0] h_rd [mhw_pkg::NUM_SLOTS];

  assign tbl_addr = s1_map_r ? AW'(s1_cell_r) : AW'(s1_wcell_r);
  assign wr_ok    = s1_vld_r && !s1_map_r
                 && (int'(s1_wcell_r) < TBL_DEPTH)
                 && (int'(s1_wslot_r) < mhw_pkg::NUM_SLOTS);

  for (genvar g = 0; g < mhw_pkg::NUM_SLOTS; g++) begin : g_tbl
    mhw_ram #(.WIDTH(COEF_BITS), .DEPTH(TBL_DEPTH)) u_ram (
      .clk   (clk),
      .we    (adv && wr_ok && (int'(s1_wslot_r) == g)),
      .waddr (tbl_addr),
      .wdata (s1_wcoef_r),
      .re    (adv),
      .raddr (tbl_addr),
      .rdata (h_rd[g])
    );
  end

  logic                             s2_vld_r;
  logic [mhw_pkg::CELL_W-1:0]       s2_cell_r;
  logic signed [mhw_pkg::OFS_W-1:0] s2_ox_r, s2_oy_r;

  // Write transactions end here.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s2_vld_r <= 1'b0;
    end else if (adv) begin
      s2_vld_r <= s1_vld_r && s1_map_r;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      s2_cell_r <= mhw_pkg::CELL_W'(s1_cell_r);
      s2_ox_r   <= s1_ox_r;
      s2_oy_r   <= s1_oy_r;
    end
  end

  // --------------------------------------------------------------------------
  // Stage 3: half-width partial products, row r uses slots 3r, 3r+1, 3r+2
  // --------------------------------------------------------------------------
  logic signed [HH+mhw_pkg::OFS_W-1:0] p3_ahi_r [3];
  logic signed [HL+mhw_pkg::OFS_W:0]   p3_alo_r [3];
  logic signed [HH+mhw_pkg::OFS_W-1:0] p3_bhi_r [3];
  logic signed [HL+mhw_pkg::OFS_W:0]   p3_blo_r [3];
  logic signed [COEF_BITS-1:0]         p3_c_r   [3];
  logic                                p3_vld_r;
  logic [mhw_pkg::CELL_W-1:0]          p3_cell_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      p3_vld_r <= 1'b0;
    end else if (adv) begin
      p3_vld_r <= s2_vld_r;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      for (int r = 0; r < 3; r++) begin
        p3_ahi_r[r] <= $signed(h_rd[3*r][COEF_BITS-1:HL]) * s2_ox_r;
        p3_alo_r[r] <= $signed({1'b0, h_rd[3*r][HL-1:0]}) * s2_ox_r;
        p3_bhi_r[r] <= $signed(h_rd[3*r+1][COEF_BITS-1:HL]) * s2_oy_r;
        p3_blo_r[r] <= $signed({1'b0, h_rd[3*r+1][HL-1:0]}) * s2_oy_r;
        p3_c_r[r]   <= $signed(h_rd[3*r+2]);
      end
      p3_cell_r <= s2_cell_r;
    end
  end

  // --------------------------------------------------------------------------
  // Stage 4: recombine halves, align constant term to Q.8
  // --------------------------------------------------------------------------
  logic signed [PW-1:0]       p4_a_r [3];
  logic signed [PW-1:0]       p4_b_r [3];
  logic signed [PW-1:0]       p4_c_r [3];
  logic                       p4_vld_r;
  logic [mhw_pkg::CELL_W-1:0] p4_cell_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      p4_vld_r <= 1'b0;
    end else if (adv) begin
      p4_vld_r <= p3_vld_r;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      for (int r = 0; r < 3; r++) begin
        p4_a_r[r] <= (PW'(p3_ahi_r[r]) <<< HL) + PW'(p3_alo_r[r]);
        p4_b_r[r] <= (PW'(p3_bhi_r[r]) <<< HL) + PW'(p3_blo_r[r]);
        p4_c_r[r] <= PW'(p3_c_r[r]) <<< mhw_pkg::FRAC_IN;
      end
      p4_cell_r <= p3_cell_r;
    end
  end

  // --------------------------------------------------------------------------
  // Stage 5: row sums, Q.40 -- row 0 is u, row 1 is v, row 2 is w
  // --------------------------------------------------------------------------
  logic signed [PW-1:0]       p5_sum_r [3];
  logic                       p5_vld_r;
  logic [mhw_pkg::CELL_W-1:0] p5_cell_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      p5_vld_r <= 1'b0;
    end else if (adv) begin
      p5_vld_r <= p4_vld_r;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      for (int r = 0; r < 3; r++) begin
        p5_sum_r[r] <= p4_a_r[r] + p4_b_r[r] + p4_c_r[r];
      end
      p5_cell_r <= p4_cell_r;
    end
  end

  // --------------------------------------------------------------------------
  // Stage 6: magnitudes, quotient signs, zero depth
  // --------------------------------------------------------------------------
  logic [PW-1:0]              p6_mag_r [3];
  logic                       p6_negu_r, p6_negv_r, p6_zero_r;
  logic                       p6_vld_r;
  logic [mhw_pkg::CELL_W-1:0] p6_cell_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      p6_vld_r <= 1'b0;
    end else if (adv) begin
      p6_vld_r <= p5_vld_r;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      for (int r = 0; r < 3; r++) begin
        p6_mag_r[r] <= p5_sum_r[r][PW-1] ? PW'(-p5_sum_r[r]) : PW'(p5_sum_r[r]);
      end
      p6_negu_r <= p5_sum_r[0][PW-1] ^ p5_sum_r[2][PW-1];
      p6_negv_r <= p5_sum_r[1][PW-1] ^ p5_sum_r[2][PW-1];
      p6_zero_r <= (p5_sum_r[2] == '0);
      p6_cell_r <= p5_cell_r;
    end
  end

  // --------------------------------------------------------------------------
  // Stage 7: overflow check of (|n| << 12) / |w| against 2^32, divider setup
  // --------------------------------------------------------------------------
  logic [PW-1:0]              hi_u, hi_v;
  logic                       ovf_u, ovf_v;
  logic [PW-1:0]              p7_remu_r, p7_remv_r, p7_den_r;
  logic [QB-1:0]              p7_lowu_r, p7_lowv_r;
  logic                       p7_ovfu_r, p7_ovfv_r;
  logic                       p7_negu_r, p7_negv_r, p7_zero_r;
  logic                       p7_vld_r;
  logic [mhw_pkg::CELL_W-1:0] p7_cell_r;

  assign hi_u  = p6_mag_r[0] >> HI_SH;
  assign hi_v  = p6_mag_r[1] >> HI_SH;
  assign ovf_u = (hi_u >= p6_mag_r[2]);
  assign ovf_v = (hi_v >= p6_mag_r[2]);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      p7_vld_r <= 1'b0;
    end else if (adv) begin
      p7_vld_r <= p6_vld_r;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      p7_remu_r <= ovf_u ? '0 : hi_u;
      p7_remv_r <= ovf_v ? '0 : hi_v;
      p7_lowu_r <= {p6_mag_r[0][HI_SH-1:0], {mhw_pkg::FRAC_OUT{1'b0}}};
      p7_lowv_r <= {p6_mag_r[1][HI_SH-1:0], {mhw_pkg::FRAC_OUT{1'b0}}};
      p7_den_r  <= p6_mag_r[2];
      p7_ovfu_r <= ovf_u;
      p7_ovfv_r <= ovf_v;
      p7_negu_r <= p6_negu_r;
      p7_negv_r <= p6_negv_r;
      p7_zero_r <= p6_zero_r;
      p7_cell_r <= p6_cell_r;
    end
  end

  // --------------------------------------------------------------------------
  // Quotient dividers, 32 stages each
  // --------------------------------------------------------------------------
  logic [QB-1:0] qu, qv;

  mhw_div_pipe #(.DW(PW), .QW(QB)) u_div_u (
    .clk   (clk),
    .en    (adv),
    .rem_i (p7_remu_r),
    .num_i (p7_lowu_r),
    .den_i (p7_den_r),
    .quo_o (qu)
  );

  mhw_div_pipe #(.DW(PW), .QW(QB)) u_div_v (
    .clk   (clk),
    .en    (adv),
    .rem_i (p7_remv_r),
    .num_i (p7_lowv_r),
    .den_i (p7_den_r),
    .quo_o (qv)
  );

  typedef struct packed {
    logic [mhw_pkg::CELL_W-1:0] cell_id;
    logic                       zero;
    logic                       negu;
    logic                       negv;
    logic                       ovfu;
    logic                       ovfv;
  } sbb_t;

  sbb_t sbb_r     [QB];
  logic sbb_vld_r [QB];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int k = 0; k < QB; k++) sbb_vld_r[k] <= 1'b0;
    end else if (adv) begin
      sbb_vld_r[0] <= p7_vld_r;
      for (int k = 1; k < QB; k++) sbb_vld_r[k] <= sbb_vld_r[k-1];
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      sbb_r[0] <= '{cell_id: p7_cell_r, zero: p7_zero_r, negu: p7_negu_r,
                    negv: p7_negv_r, ovfu: p7_ovfu_r, ovfv: p7_ovfv_r};
      for (int k = 1; k < QB; k++) sbb_r[k] <= sbb_r[k-1];
    end
  end

  // --------------------------------------------------------------------------
  // Output stage: sign, saturate, zero-depth override
  // --------------------------------------------------------------------------
  sbb_t          sb;
  logic          clip_u, clip_v;
  logic [QB-1:0] val_u, val_v;

  assign sb = sbb_r[QB-1];

  always_comb begin
    clip_u = sb.ovfu || (!sb.negu && qu[QB-1]) || (sb.negu && qu > mhw_pkg::SAT_NEG);
    clip_v = sb.ovfv || (!sb.negv && qv[QB-1]) || (sb.negv && qv > mhw_pkg::SAT_NEG);
    if (clip_u)       val_u = sb.negu ? mhw_pkg::SAT_NEG : mhw_pkg::SAT_POS;
    else if (sb.negu) val_u = ~qu + QB'(1);
    else              val_u = qu;
    if (clip_v)       val_v = sb.negv ? mhw_pkg::SAT_NEG : mhw_pkg::SAT_POS;
    else if (sb.negv) val_v = ~qv + QB'(1);
    else              val_v = qv;
  end

  logic [QB-1:0]              out_u_r, out_v_r;
  logic [mhw_pkg::CELL_W-1:0] out_cell_r;
  logic                       out_zero_r, out_clip_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (adv) begin
      out_valid_r <= sbb_vld_r[QB-1];
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      out_u_r    <= sb.zero ? '0 : val_u;
      out_v_r    <= sb.zero ? '0 : val_v;
      out_cell_r <= sb.cell_id;
      out_zero_r <= sb.zero;
      out_clip_r <= !sb.zero && (clip_u || clip_v);
    end
  end

  assign out_valid      = out_valid_r;
  assign out_source_u   = $signed(out_u_r);
  assign out_source_v   = $signed(out_v_r);
  assign out_used_cell  = out_cell_r;
  assign out_zero_depth = out_zero_r;
  assign out_clipped    = out_clip_r;

  // --------------------------------------------------------------------------
  // Assertions
  // --------------------------------------------------------------------------
  a_zero_depth_forces_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && out_zero_r |-> out_u_r == '0 && out_v_r == '0 && !out_clip_r)
    else $error("zero depth result not forced to zero");

  a_clip_saturates: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && out_clip_r |->
      out_u_r == mhw_pkg::SAT_POS || out_u_r == mhw_pkg::SAT_NEG ||
      out_v_r == mhw_pkg::SAT_POS || out_v_r == mhw_pkg::SAT_NEG)
    else $error("clipped result without saturated coordinate");

  a_stall_holds_pipe: assert property (@(posedge clk) disable iff (!rst_n)
    !adv |=> $stable(p7_vld_r) && $stable(sbb_vld_r[QB-1]) && $stable(s2_vld_r))
    else $error("pipeline moved during stall");

endmodule

// File: hw/rtl/mhw_ram.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mhw_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
module mhw_ram #(
  parameter int WIDTH = 48,
  parameter int DEPTH = 4096
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata_r <= mem[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

// File: hw/rtl/mhw_div_pipe.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mhw_div_pipe
// Pipelined restoring divider, one quotient bit per stage. The starting
// remainder must be below the divisor; QW numerator bits shift in MSB first.
// ----------------------------------------------------------------------------
module mhw_div_pipe #(
  parameter int DW = 16,
  parameter int QW = 8
) (
  input  logic          clk,
  input  logic          en,
  input  logic [DW-1:0] rem_i,
  input  logic [QW-1:0] num_i,
  input  logic [DW-1:0] den_i,
  output logic [QW-1:0] quo_o
);

  logic [DW-1:0] rem_r [QW];
  logic [DW-1:0] den_r [QW];
  logic [QW-1:0] nb_r  [QW];
  logic [QW-1:0] q_r   [QW];

  logic [DW-1:0] rem_p [QW];
  logic [DW-1:0] den_p [QW];
  logic [QW-1:0] nb_p  [QW];
  logic [QW-1:0] q_p   [QW];
  logic [DW:0]   trial [QW];
  logic [DW:0]   diff  [QW];
  logic          ge    [QW];

  always_comb begin
    for (int k = 0; k < QW; k++) begin
      if (k == 0) begin
        rem_p[k] = rem_i;
        den_p[k] = den_i;
        nb_p[k]  = num_i;
        q_p[k]   = '0;
      end else begin
        rem_p[k] = rem_r[k-1];
        den_p[k] = den_r[k-1];
        nb_p[k]  = nb_r[k-1];
        q_p[k]   = q_r[k-1];
      end
      trial[k] = {rem_p[k], nb_p[k][QW-1]};
      diff[k]  = trial[k] - {1'b0, den_p[k]};
      ge[k]    = (trial[k] >= {1'b0, den_p[k]});
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      for (int k = 0; k < QW; k++) begin
        rem_r[k] <= ge[k] ? diff[k][DW-1:0] : trial[k][DW-1:0];
        den_r[k] <= den_p[k];
        nb_r[k]  <= nb_p[k] << 1;
        q_r[k]   <= (q_p[k] << 1) | QW'(ge[k]);
      end
    end
  end

  assign quo_o = q_r[QW-1];

endmodule
